// ===== rtl/tmnp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmnp_pkg
// Shared types and constants for the thruster mixer, normalizer and pulse
// width converter.
// ----------------------------------------------------------------------------
package tmnp_pkg;

	// Field and datapath widths
	localparam int EFF_W    = 16;              // one effort field, Q2.14
	localparam int VAL_W    = 18;              // one mixed value, signed
	localparam int MAG_W    = 17;              // magnitudes, largest value, quotient
	localparam int FRAC_W   = 14;              // fraction bits of Q2.14
	localparam int GAIN_W   = 15;
	localparam int PULSE_W  = 12;
	localparam int SPAN_W   = 11;
	localparam int N_THR    = 8;
	localparam int N_EFF    = 6;
	localparam int DIV_N    = MAG_W;           // one quotient bit per divider stage
	localparam int IN_W     = N_EFF * EFF_W;   // 96
	localparam int OUT_W    = N_THR * PULSE_W; // 96
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = GAIN_W;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	// Largest value at or below this is left unscaled (1.0 in Q2.14)
	localparam logic [MAG_W-1:0] ONE_Q14 = MAG_W'(16384);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_SPAN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd4;

	// Register reset values
	localparam logic [GAIN_W-1:0]  RST_ROTATE_GAIN  = 15'd23170;
	localparam logic [PULSE_W-1:0] RST_PULSE_CENTER = 12'd1500;
	localparam logic [SPAN_W-1:0]  RST_PULSE_SPAN   = 11'd400;
	localparam logic [PULSE_W-1:0] RST_PULSE_MIN    = 12'd1100;
	localparam logic [PULSE_W-1:0] RST_PULSE_MAX    = 12'd1900;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  rotate_gain;
		logic [PULSE_W-1:0] pulse_center;
		logic [SPAN_W-1:0]  pulse_span;
		logic [PULSE_W-1:0] pulse_min;
		logic [PULSE_W-1:0] pulse_max;
	} cfg_t;

	// One mixed item handed from the front to the back
	typedef struct packed {
		logic [N_THR-1:0][VAL_W-1:0] v;
		logic [MAG_W-1:0]            m;
		logic                        scaled;
	} mix_t;

endpackage

// ===== rtl/thruster_mix_normalize_pwm_core.sv =====
// ----------------------------------------------------------------------------
// thruster_mix_normalize_pwm_core
// Mixes six efforts into eight thruster pulse widths with normalization.
// ----------------------------------------------------------------------------
// One item per clock sustained while the sink is ready. The normalizing divider
// produces one quotient bit per stage for all eight thrusters (17 stages),
// behind a four-stage mixing front and a four-entry queue that lets the front
// keep accepting while results wait. Configuration writes take effect at once;
// the user must make them while no item is in flight (the block does not enforce it).
module thruster_mix_normalize_pwm_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// surge, sway, heave, pitch, roll, yaw (16 bits each, lowest first)
	input  logic [tmnp_pkg::IN_W-1:0]          s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// h_front_left, h_front_right, h_back_left, h_back_right,
	// v_front_left, v_front_right, v_back_left, v_back_right (12 bits each)
	output logic [tmnp_pkg::OUT_W-1:0]         m_tdata,
	// was_scaled
	output logic                               m_tuser,
	input  logic                               cfg_we,
	input  logic [tmnp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tmnp_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import tmnp_pkg::*;

	cfg_t cfg_q;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	mix_t fq_data, bq_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotate_gain  <= RST_ROTATE_GAIN;
			cfg_q.pulse_center <= RST_PULSE_CENTER;
			cfg_q.pulse_span   <= RST_PULSE_SPAN;
			cfg_q.pulse_min    <= RST_PULSE_MIN;
			cfg_q.pulse_max    <= RST_PULSE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROTATE_GAIN:  cfg_q.rotate_gain  <= cfg_data[GAIN_W-1:0];
				REG_PULSE_CENTER: cfg_q.pulse_center <= cfg_data[PULSE_W-1:0];
				REG_PULSE_SPAN:   cfg_q.pulse_span   <= cfg_data[SPAN_W-1:0];
				REG_PULSE_MIN:    cfg_q.pulse_min    <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX:    cfg_q.pulse_max    <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	tmnp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	tmnp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_data  (bq_data)
	);

	tmnp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (bq_valid),
		.q_ready    (bq_ready),
		.q_data     (bq_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pulse  (m_tdata),
		.out_scaled (m_tuser)
	);

	// A front item refused by the queue stays put
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fq_valid && !fq_ready |=> fq_valid && $stable(fq_data))
		else $error("front item changed while queue full");

	// Scaling is flagged only when the largest value exceeds one
	a_scaled_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fq_valid |-> (fq_data.scaled == (fq_data.m > ONE_Q14)))
		else $error("scale flag disagrees with largest value");

	// The first and last pulses stay within the bounds when the bounds are ordered
	a_pulse_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cfg_q.pulse_min <= cfg_q.pulse_max) |->
		(m_tdata[PULSE_W-1:0] >= cfg_q.pulse_min) &&
		(m_tdata[PULSE_W-1:0] <= cfg_q.pulse_max) &&
		(m_tdata[OUT_W-1 -: PULSE_W] >= cfg_q.pulse_min) &&
		(m_tdata[OUT_W-1 -: PULSE_W] <= cfg_q.pulse_max))
		else $error("pulse width outside bounds");

endmodule

// ===== rtl/tmnp_fifo.sv =====
// ----------------------------------------------------------------------------
// tmnp_fifo
// Short register queue between the mixing front and the scaling back.
// ----------------------------------------------------------------------------
module tmnp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tmnp_pkg::mix_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tmnp_pkg::mix_t out_data
);
	import tmnp_pkg::*;

	mix_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/tmnp_front.sv =====
// ----------------------------------------------------------------------------
// tmnp_front
// Accepts effort items, mixes them into eight thruster values and finds the
// largest positive value, which decides whether the item needs scaling.
// ----------------------------------------------------------------------------
module tmnp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tmnp_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tmnp_pkg::IN_W-1:0]     in_data,
	output logic                          q_valid,
	input  logic                          q_ready,
	output tmnp_pkg::mix_t                q_data
);
	import tmnp_pkg::*;

	logic en;

	// Stage 1: sums and vertical mix
	logic                     vld_s1;
	logic signed [EFF_W:0]    sum_s1;
	logic signed [EFF_W:0]    dif_s1;
	logic signed [EFF_W-1:0]  yaw_s1;
	val_t                     vert_s1 [4];

	// Stage 2: rotation products
	logic                     vld_s2;
	logic signed [32:0]       pa_s2;
	logic signed [32:0]       pb_s2;
	logic signed [EFF_W-1:0]  yaw_s2;
	val_t                     vert_s2 [4];

	// Stage 3: all eight values
	logic                     vld_s3;
	val_t                     v_s3 [N_THR];

	// Stage 4: classified item
	logic                     vld_s4;
	mix_t                     mix_s4;

	logic signed [EFF_W-1:0] surge, sway, heave, pitch, roll, yaw;
	val_t hv, pv, rv;
	logic signed [32:0] pa_adj, pb_adj;
	val_t a_v, b_v, y_v;
	val_t mx;
	mix_t mix_d;

	assign en       = !vld_s4 || q_ready;
	assign in_ready = en;
	assign q_valid  = vld_s4;
	assign q_data   = mix_s4;

	assign surge = in_data[0*EFF_W +: EFF_W];
	assign sway  = in_data[1*EFF_W +: EFF_W];
	assign heave = in_data[2*EFF_W +: EFF_W];
	assign pitch = in_data[3*EFF_W +: EFF_W];
	assign roll  = in_data[4*EFF_W +: EFF_W];
	assign yaw   = in_data[5*EFF_W +: EFF_W];
	assign hv    = VAL_W'(heave);
	assign pv    = VAL_W'(pitch);
	assign rv    = VAL_W'(roll);

	// Round rotation products toward zero, then add yaw
	assign pa_adj = pa_s2 + (pa_s2[32] ? 33'sd32767 : 33'sd0);
	assign pb_adj = pb_s2 + (pb_s2[32] ? 33'sd32767 : 33'sd0);
	assign a_v    = val_t'(pa_adj >>> 15);
	assign b_v    = val_t'(pb_adj >>> 15);
	assign y_v    = VAL_W'(yaw_s2);

	// Find the largest value, counting from zero upward
	always_comb begin
		mx = '0;
		for (int i = 0; i < N_THR; i++) begin
			if (v_s3[i] > mx) mx = v_s3[i];
		end
		for (int i = 0; i < N_THR; i++) begin
			mix_d.v[i] = v_s3[i];
		end
		mix_d.m      = mx[MAG_W-1:0];
		mix_d.scaled = (mx[MAG_W-1:0] > ONE_Q14);
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1     <= (EFF_W+1)'(surge) + (EFF_W+1)'(sway);
			dif_s1     <= (EFF_W+1)'(surge) - (EFF_W+1)'(sway);
			yaw_s1     <= yaw;
			vert_s1[0] <= hv - pv + rv;
			vert_s1[1] <= hv - pv - rv;
			vert_s1[2] <= hv + pv + rv;
			vert_s1[3] <= hv + pv - rv;

			pa_s2   <= 33'($signed({1'b0, cfg.rotate_gain})) * 33'(sum_s1);
			pb_s2   <= 33'($signed({1'b0, cfg.rotate_gain})) * 33'(dif_s1);
			yaw_s2  <= yaw_s1;
			vert_s2 <= vert_s1;

			v_s3[0] <= b_v - y_v;
			v_s3[1] <= a_v + y_v;
			v_s3[2] <= a_v - y_v;
			v_s3[3] <= b_v + y_v;
			v_s3[4] <= vert_s2[0];
			v_s3[5] <= vert_s2[1];
			v_s3[6] <= vert_s2[2];
			v_s3[7] <= vert_s2[3];

			mix_s4 <= mix_d;
		end
	end

endmodule

// ===== rtl/tmnp_back.sv =====
// ----------------------------------------------------------------------------
// tmnp_back
// Divides each value by the largest one where needed (one quotient bit per
// stage) and converts the values into clamped pulse widths.
// ----------------------------------------------------------------------------
module tmnp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tmnp_pkg::cfg_t             cfg,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  tmnp_pkg::mix_t             q_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tmnp_pkg::OUT_W-1:0] out_pulse,
	output logic                       out_scaled
);
	import tmnp_pkg::*;

	typedef struct packed {
		logic             neg;
		logic [VAL_W-1:0] v;
		logic [MAG_W-1:0] r;
		logic [MAG_W-1:0] low;
		logic [MAG_W-1:0] q;
	} lane_t;

	typedef struct packed {
		lane_t [N_THR-1:0] ln;
		logic [MAG_W-1:0]  m;
		logic              scaled;
	} div_t;

	logic en;
	logic vld_s [DIV_N+1];
	div_t div_s [DIV_N+1];
	div_t ent;

	logic vld_sel_s;
	logic scaled_sel_s;
	val_t vsel_s [N_THR];
	logic vld_mul_s;
	logic scaled_mul_s;
	logic signed [VAL_W+SPAN_W:0] prod_s [N_THR];
	logic                  out_vld_q;
	logic [OUT_W-1:0]      pulse_q;
	logic                  scaled_q;

	logic [PULSE_W-1:0]    clamp_d [N_THR];
	logic signed [VAL_W+SPAN_W+1:0] p_full [N_THR];
	logic signed [VAL_W+SPAN_W+1:0] hi_b, lo_b, ctr_b;

	function automatic div_t div_step(input div_t x);
		div_t             y;
		logic [MAG_W:0]   rs;
		logic             ge;
		y = x;
		for (int i = 0; i < N_THR; i++) begin
			rs = {x.ln[i].r, x.ln[i].low[MAG_W-1]};
			ge = (rs >= {1'b0, x.m});
			y.ln[i].r   = ge ? MAG_W'(rs - {1'b0, x.m}) : rs[MAG_W-1:0];
			y.ln[i].low = {x.ln[i].low[MAG_W-2:0], 1'b0};
			y.ln[i].q   = {x.ln[i].q[MAG_W-2:0], ge};
		end
		return y;
	endfunction

	assign en         = !out_vld_q || out_ready;
	assign q_ready    = en;
	assign out_valid  = out_vld_q;
	assign out_pulse  = pulse_q;
	assign out_scaled = scaled_q;

	// Split each value into sign and magnitude; seed the remainder
	always_comb begin
		logic [VAL_W-1:0] mag;
		ent.m      = q_data.m;
		ent.scaled = q_data.scaled;
		for (int i = 0; i < N_THR; i++) begin
			mag            = q_data.v[i][VAL_W-1] ? (~q_data.v[i] + 1'b1) : q_data.v[i];
			ent.ln[i].neg  = q_data.v[i][VAL_W-1];
			ent.ln[i].v    = q_data.v[i];
			ent.ln[i].r    = MAG_W'(mag[MAG_W-1:3]);
			ent.ln[i].low  = {mag[2:0], {FRAC_W{1'b0}}};
			ent.ln[i].q    = '0;
		end
	end

	// Clamp to the pulse bounds, upper bound first
	assign ctr_b = (VAL_W+SPAN_W+2)'($signed({1'b0, cfg.pulse_center, {FRAC_W{1'b0}}}));
	assign hi_b  = (VAL_W+SPAN_W+2)'($signed({1'b0, cfg.pulse_max, {FRAC_W{1'b0}}}));
	assign lo_b  = (VAL_W+SPAN_W+2)'($signed({1'b0, cfg.pulse_min, {FRAC_W{1'b0}}}));
	always_comb begin
		for (int i = 0; i < N_THR; i++) begin
			p_full[i]  = ctr_b + (VAL_W+SPAN_W+2)'(prod_s[i]);
			if (p_full[i] > hi_b) clamp_d[i] = cfg.pulse_max;
			else if (p_full[i] < lo_b) clamp_d[i] = cfg.pulse_min;
			else clamp_d[i] = p_full[i][FRAC_W +: PULSE_W];
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_N; k++) vld_s[k] <= 1'b0;
			vld_sel_s <= 1'b0;
			vld_mul_s <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= q_valid;
			for (int k = 1; k <= DIV_N; k++) vld_s[k] <= vld_s[k-1];
			vld_sel_s <= vld_s[DIV_N];
			vld_mul_s <= vld_sel_s;
			out_vld_q <= vld_mul_s;
		end
	end

	// Divider stages: one quotient bit per stage for all lanes
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= ent;
			for (int k = 1; k <= DIV_N; k++) div_s[k] <= div_step(div_s[k-1]);
		end
	end

	// Select scaled value, multiply by span, clamp
	always_ff @(posedge clk) begin
		if (en) begin
			scaled_sel_s <= div_s[DIV_N].scaled;
			for (int i = 0; i < N_THR; i++) begin
				if (!div_s[DIV_N].scaled) vsel_s[i] <= $signed(div_s[DIV_N].ln[i].v);
				else if (div_s[DIV_N].ln[i].neg)
					vsel_s[i] <= -$signed({1'b0, div_s[DIV_N].ln[i].q});
				else vsel_s[i] <= $signed({1'b0, div_s[DIV_N].ln[i].q});
			end
			scaled_mul_s <= scaled_sel_s;
			for (int i = 0; i < N_THR; i++) begin
				prod_s[i] <= (VAL_W+SPAN_W+1)'(vsel_s[i]) *
					(VAL_W+SPAN_W+1)'($signed({1'b0, cfg.pulse_span}));
			end
			scaled_q <= scaled_mul_s;
			for (int i = 0; i < N_THR; i++) begin
				pulse_q[i*PULSE_W +: PULSE_W] <= clamp_d[i];
			end
		end
	end

endmodule

// ===== tb/thruster_mix_normalize_pwm_core_test.sv =====
// ----------------------------------------------------------------------------
// thruster_mix_normalize_pwm_core_test
// Drives effort items through the thruster mixer under random source gaps and
// sink stalls, predicts each set of pulse widths and checks every field.
// ----------------------------------------------------------------------------
module thruster_mix_normalize_pwm_core_test;
	import tmnp_pkg::*;

	localparam int LATENCY   = 25;
	localparam int IDLE_MAX  = 20000;

	typedef struct packed {
		logic [N_THR-1:0][PULSE_W-1:0] pulse;
		logic                          scaled;
	} pulses_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Predictor copy of the registers
	logic [GAIN_W-1:0]  mix_gain;
	logic [PULSE_W-1:0] mix_center;
	logic [SPAN_W-1:0]  mix_span;
	logic [PULSE_W-1:0] mix_min;
	logic [PULSE_W-1:0] mix_max;

	logic [IN_W-1:0] effort_queue[$];
	pulses_t         pulse_queue[$];
	int              error_count;
	int              idle_cycles;
	bit              hold_source;
	int              burst_left;
	int              gap_left;
	int              stall_phase;

	thruster_mix_normalize_pwm_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint trunc_div(longint num, longint den);
		longint q;
		q = (num < 0 ? -num : num) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic [PULSE_W-1:0] pulse_width(longint v);
		longint p;
		p = longint'(mix_center) * 16384 + v * longint'(mix_span);
		if (p > longint'(mix_max) * 16384) return mix_max;
		if (p < longint'(mix_min) * 16384) return mix_min;
		return PULSE_W'(trunc_div(p, 16384));
	endfunction

	// Mix, normalize and convert one effort item
	function automatic pulses_t mix_thrusters(logic [IN_W-1:0] d);
		longint e[N_EFF];
		longint v[N_THR];
		longint a, b, m;
		pulses_t r;
		for (int i = 0; i < N_EFF; i++)
			e[i] = longint'($signed(d[i*EFF_W +: EFF_W]));
		a = trunc_div(longint'(mix_gain) * (e[0] + e[1]), 32768);
		b = trunc_div(longint'(mix_gain) * (e[0] - e[1]), 32768);
		v[0] = b - e[5];
		v[1] = a + e[5];
		v[2] = a - e[5];
		v[3] = b + e[5];
		v[4] = e[2] - e[3] + e[4];
		v[5] = e[2] - e[3] - e[4];
		v[6] = e[2] + e[3] + e[4];
		v[7] = e[2] + e[3] - e[4];
		m = 0;
		for (int i = 0; i < N_THR; i++)
			if (v[i] > m) m = v[i];
		r.scaled = (m > 16384);
		for (int i = 0; i < N_THR; i++) begin
			if (r.scaled) v[i] = trunc_div(v[i] * 16384, m);
			r.pulse[i] = pulse_width(v[i]);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	// Write one register while idle, keep the predictor in step
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROTATE_GAIN:  mix_gain = val;
			REG_PULSE_CENTER: mix_center = val[PULSE_W-1:0];
			REG_PULSE_SPAN:   mix_span = val[SPAN_W-1:0];
			REG_PULSE_MIN:    mix_min = val[PULSE_W-1:0];
			REG_PULSE_MAX:    mix_max = val[PULSE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (effort_queue.size() == 0 && !s_tvalid && pulse_queue.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [EFF_W-1:0] rand_effort();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return EFF_W'($urandom_range(0, 32768) - 16384);
			3: return EFF_W'($urandom_range(0, 8192) - 4096);
			default: return EFF_W'($urandom);
		endcase
	endfunction

	task automatic add_item(logic [EFF_W-1:0] s0, logic [EFF_W-1:0] s1, logic [EFF_W-1:0] s2,
			logic [EFF_W-1:0] s3, logic [EFF_W-1:0] s4, logic [EFF_W-1:0] s5);
		effort_queue.push_back({s5, s4, s3, s2, s1, s0});
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			add_item(rand_effort(), rand_effort(), rand_effort(),
				rand_effort(), rand_effort(), rand_effort());
	endtask

	// Stimulus and configuration phases
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mix_gain = RST_ROTATE_GAIN;
		mix_center = RST_PULSE_CENTER;
		mix_span = RST_PULSE_SPAN;
		mix_min = RST_PULSE_MIN;
		mix_max = RST_PULSE_MAX;
		error_count = 0;
		hold_source = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// directed items at reset settings
		add_item(0, 0, 0, 0, 0, 0);
		add_item(16'h4000, 0, 0, 0, 0, 0);
		add_item(0, 16'h4000, 16'h4000, 0, 0, 0);
		add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_item(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		add_item(0, 0, 16'h4001, 0, 0, 0);
		add_item(0, 0, 16'hC000, 16'hC000, 0, 0);
		add_item(0, 0, 0, 0, 0, 16'h4000);
		add_item(0, 0, 0, 0, 16'h2000, 16'h9000);
		add_item(16'h1234, 16'hEDCC, 16'h0001, 16'hFFFF, 16'h0FFF, 16'hF001);
		drain();
		// min above max, zero gain
		write_reg(REG_ROTATE_GAIN, CFG_DAT_W'(0));
		write_reg(REG_PULSE_MIN, CFG_DAT_W'(2000));
		write_reg(REG_PULSE_MAX, CFG_DAT_W'(1000));
		add_item(16'h4000, 16'h4000, 0, 0, 0, 0);
		add_item(0, 0, 16'hC000, 0, 0, 0);
		add_item(0, 0, 0, 0, 0, 0);
		add_random(20);
		drain();
		// extremes of every register
		write_reg(REG_ROTATE_GAIN, CFG_DAT_W'(32767));
		write_reg(REG_PULSE_CENTER, CFG_DAT_W'(4095));
		write_reg(REG_PULSE_SPAN, CFG_DAT_W'(2047));
		write_reg(REG_PULSE_MIN, CFG_DAT_W'(0));
		write_reg(REG_PULSE_MAX, CFG_DAT_W'(4095));
		add_random(120);
		drain();
		write_reg(REG_PULSE_CENTER, CFG_DAT_W'(0));
		write_reg(REG_PULSE_SPAN, CFG_DAT_W'(0));
		add_random(40);
		drain();
		write_reg(REG_PULSE_SPAN, CFG_DAT_W'(2047));
		write_reg(REG_PULSE_CENTER, CFG_DAT_W'(2048));
		add_random(100);
		drain();
		// random register settings
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_ROTATE_GAIN, CFG_DAT_W'($urandom));
			write_reg(REG_PULSE_CENTER, CFG_DAT_W'($urandom_range(0, 4095)));
			write_reg(REG_PULSE_SPAN, CFG_DAT_W'($urandom_range(0, 2047)));
			write_reg(REG_PULSE_MIN, CFG_DAT_W'($urandom_range(0, 2000)));
			write_reg(REG_PULSE_MAX, CFG_DAT_W'($urandom_range(2000, 4095)));
			add_random(55);
			drain();
		end
		// back to reset values; hold the source until all results are in
		write_reg(REG_ROTATE_GAIN, CFG_DAT_W'(RST_ROTATE_GAIN));
		write_reg(REG_PULSE_CENTER, CFG_DAT_W'(RST_PULSE_CENTER));
		write_reg(REG_PULSE_SPAN, CFG_DAT_W'(RST_PULSE_SPAN));
		write_reg(REG_PULSE_MIN, CFG_DAT_W'(RST_PULSE_MIN));
		write_reg(REG_PULSE_MAX, CFG_DAT_W'(RST_PULSE_MAX));
		add_random(30);
		wait (effort_queue.size() < 15);
		hold_source = 1'b1;
		wait (!s_tvalid && pulse_queue.size() == 0);
		hold_source = 1'b0;
		drain();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Driver: bursts of items separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) pulse_queue.push_back(mix_thrusters(s_tdata));
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (effort_queue.size() > 0 && !hold_source) begin
				s_tvalid <= 1'b1;
				s_tdata <= effort_queue.pop_front();
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink stalls: alternate free-running, random and patterned stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase < 40) m_tready <= 1'b1;
			else if (stall_phase < 70) m_tready <= ($urandom_range(0, 2) != 0);
			else m_tready <= stall_phase[2];
		end
	end

	// Monitor: compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pulses_t want;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(pulse_queue.size() == 0 && !s_tvalid))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (pulse_queue.size() == 0) begin
					report_mismatch("unexpected item", 1, 0);
				end else begin
					want = pulse_queue.pop_front();
					for (int i = 0; i < N_THR; i++)
						if (m_tdata[i*PULSE_W +: PULSE_W] != want.pulse[i])
							report_mismatch($sformatf("pulse %0d", i),
								m_tdata[i*PULSE_W +: PULSE_W], want.pulse[i]);
					if (m_tuser != want.scaled)
						report_mismatch("was_scaled", m_tuser, want.scaled);
				end
			end
		end
	end

endmodule
